FILE: rtl/bqpe_pkg.sv
// package: shared types, constants and helpers for the patch evaluator
`timescale 1ns / 1ps
package bqpe_pkg;

   localparam logic [16:0] FRAC_ONE = 17'd65536;
   localparam logic [15:0] NORM_ONE = 16'd16384;
   localparam logic        FUNC_LOAD = 1'b0;
   localparam logic        FUNC_EVAL = 1'b1;
   localparam logic [3:0]  LAST_SLOT = 4'd8;

   // surface result fields
   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
   } result_type;

   // bernstein weights in q.32, w0 = (1-p)^2, w1 = 2(1-p)p, w2 = p^2
   typedef struct packed {
      logic [33:0] w0;
      logic [33:0] w1;
      logic [33:0] w2;
   } weight_type;

   // leading magnitude position: returns shift amount that brings top into [2^29,2^30)
   function automatic logic signed [7:0] norm_shift(input logic [63:0] top);
      logic signed [7:0] r;
      r = 8'sd0;
      for (int i = 0; i < 64; i++) begin
         if (top[i]) begin
            r = 8'(29 - i);
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/bqpe_normal_unit.sv
// normal unit: scaling, cross product, length and per-component division pipeline
`timescale 1ns / 1ps
module bqpe_normal_unit
   import bqpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic signed [63:0] dt_x,
   input  logic signed [63:0] dt_y,
   input  logic signed [63:0] dt_z,
   input  logic signed [63:0] ds_x,
   input  logic signed [63:0] ds_y,
   input  logic signed [63:0] ds_z,
   output logic signed [15:0] norm_x,
   output logic signed [15:0] norm_y,
   output logic signed [15:0] norm_z
);

   localparam int SQ_STEPS = 32;
   localparam int DV_STEPS = 16;

   // magnitude of a signed 64-bit value
   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // apply a signed shift to a magnitude
   function automatic logic [63:0] apply_shift(input logic [63:0] m,
                                                input logic signed [7:0] sh);
      logic [63:0] r;
      if (sh[7]) r = m >> 7'(-sh);
      else       r = m << 7'(sh);
      return r;
   endfunction

   // signed scaled vector in 31 bits
   function automatic logic signed [31:0] sgn31(input logic neg, input logic [63:0] m);
      logic signed [31:0] v;
      v = $signed({1'b0, m[30:0]});
      return neg ? -v : v;
   endfunction

   // stage a: scale both derivative vectors
   logic signed [31:0] a_ff [3], a_in [3];
   logic signed [31:0] b_ff [3], b_in [3];
   always_comb begin
      logic [63:0] m [3];
      logic [63:0] top;
      logic signed [7:0] sh;
      logic signed [63:0] v [3];
      v[0] = dt_x; v[1] = dt_y; v[2] = dt_z;
      top = '0;
      for (int k = 0; k < 3; k++) begin
         m[k] = mag64(v[k]);
         if (m[k] > top) top = m[k];
      end
      sh = norm_shift(top);
      for (int k = 0; k < 3; k++) a_in[k] = sgn31(v[k][63], apply_shift(m[k], sh));
      v[0] = ds_x; v[1] = ds_y; v[2] = ds_z;
      top = '0;
      for (int k = 0; k < 3; k++) begin
         m[k] = mag64(v[k]);
         if (m[k] > top) top = m[k];
      end
      sh = norm_shift(top);
      for (int k = 0; k < 3; k++) b_in[k] = sgn31(v[k][63], apply_shift(m[k], sh));
   end

   // stage b: six partial products
   logic signed [63:0] p_ff [6];
   // stage c: cross product
   logic signed [63:0] n_ff [3];
   // stage d: scaled cross product magnitudes and signs
   logic [29:0] sm_ff [3];
   logic [2:0]  sn_ff;
   logic        zero_ff;
   // stage e: squares
   logic [59:0] sq_ff [3];
   // stage f: sum of squares
   logic [61:0] l2_ff;

   logic [63:0] sm_in [3];
   logic        zero_in;
   always_comb begin
      logic [63:0] top;
      logic signed [7:0] sh;
      logic [63:0] m [3];
      top = '0;
      for (int k = 0; k < 3; k++) begin
         m[k] = mag64(n_ff[k]);
         if (m[k] > top) top = m[k];
      end
      zero_in = (top == 64'd0);
      sh = norm_shift(top);
      for (int k = 0; k < 3; k++) sm_in[k] = apply_shift(m[k], sh);
   end

   // carried along the square root pipe
   typedef struct packed {
      logic [29:0] m0;
      logic [29:0] m1;
      logic [29:0] m2;
      logic [2:0]  sn;
      logic        zero;
   } side_type;

   side_type sd_ff, se_ff;
   side_type sq_side_ff [SQ_STEPS];
   logic [61:0] sq_x_ff [SQ_STEPS];
   logic [31:0] sq_r_ff [SQ_STEPS];

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         p_ff[0] <= 64'(a_ff[1]) * 64'(b_ff[2]);
         p_ff[1] <= 64'(a_ff[2]) * 64'(b_ff[1]);
         p_ff[2] <= 64'(a_ff[2]) * 64'(b_ff[0]);
         p_ff[3] <= 64'(a_ff[0]) * 64'(b_ff[2]);
         p_ff[4] <= 64'(a_ff[0]) * 64'(b_ff[1]);
         p_ff[5] <= 64'(a_ff[1]) * 64'(b_ff[0]);
         n_ff[0] <= p_ff[0] - p_ff[1];
         n_ff[1] <= p_ff[2] - p_ff[3];
         n_ff[2] <= p_ff[4] - p_ff[5];
         for (int k = 0; k < 3; k++) sm_ff[k] <= sm_in[k][29:0];
         sn_ff <= {n_ff[2][63], n_ff[1][63], n_ff[0][63]};
         zero_ff <= zero_in;
         for (int k = 0; k < 3; k++) sq_ff[k] <= sm_ff[k] * sm_ff[k];
         sd_ff <= '{sm_ff[0], sm_ff[1], sm_ff[2], sn_ff, zero_ff};
         l2_ff <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
         se_ff <= sd_ff;
      end
   end

   // square root: one result bit per stage
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < SQ_STEPS; i++) begin
            logic [61:0] x;
            logic [31:0] r;
            logic [63:0] trial;
            logic [63:0] rem;
            if (i == 0) begin
               x = l2_ff; r = '0; sq_side_ff[i] <= se_ff;
            end else begin
               x = sq_x_ff[i-1]; r = sq_r_ff[i-1]; sq_side_ff[i] <= sq_side_ff[i-1];
            end
            // restoring step on bit pair 31-i
            rem = 64'(x) >> (2 * (31 - i));
            trial = {30'd0, r, 2'b01};
            if ((rem & 64'hFFFF_FFFF_FFFF_FFFF) >= trial) begin
               sq_x_ff[i] <= x - 62'(trial << (2 * (31 - i)));
               sq_r_ff[i] <= {r[30:0], 1'b1};
            end else begin
               sq_x_ff[i] <= x;
               sq_r_ff[i] <= {r[30:0], 1'b0};
            end
         end
      end
   end

   // division: q = (m*16384 + len/2) / len, one quotient bit per stage
   side_type dv_side_ff [DV_STEPS];
   logic [31:0] dv_len_ff [DV_STEPS];
   logic [45:0] dv_rem_ff [3][DV_STEPS];
   logic [15:0] dv_q_ff [3][DV_STEPS];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DV_STEPS; i++) begin
            logic [31:0] len;
            logic [45:0] rm [3];
            logic [15:0] q [3];
            logic [46:0] d;
            if (i == 0) begin
               len = sq_r_ff[SQ_STEPS-1];
               dv_side_ff[i] <= sq_side_ff[SQ_STEPS-1];
               rm[0] = {2'b0, sq_side_ff[SQ_STEPS-1].m0, 14'd0} + 46'(len >> 1);
               rm[1] = {2'b0, sq_side_ff[SQ_STEPS-1].m1, 14'd0} + 46'(len >> 1);
               rm[2] = {2'b0, sq_side_ff[SQ_STEPS-1].m2, 14'd0} + 46'(len >> 1);
               q[0] = '0; q[1] = '0; q[2] = '0;
            end else begin
               len = dv_len_ff[i-1];
               dv_side_ff[i] <= dv_side_ff[i-1];
               for (int k = 0; k < 3; k++) begin
                  rm[k] = dv_rem_ff[k][i-1];
                  q[k] = dv_q_ff[k][i-1];
               end
            end
            dv_len_ff[i] <= len;
            for (int k = 0; k < 3; k++) begin
               d = {15'd0, len} << (15 - i);
               if ({1'b0, rm[k]} >= d) begin
                  dv_rem_ff[k][i] <= rm[k] - 46'(d);
                  dv_q_ff[k][i] <= q[k] | (16'd1 << (15 - i));
               end else begin
                  dv_rem_ff[k][i] <= rm[k];
                  dv_q_ff[k][i] <= q[k];
               end
            end
         end
      end
   end

   // saturate, sign and degenerate case
   always_comb begin
      logic [15:0] q [3];
      side_type sd;
      sd = dv_side_ff[DV_STEPS-1];
      for (int k = 0; k < 3; k++) begin
         q[k] = dv_q_ff[k][DV_STEPS-1];
         if (q[k] > NORM_ONE) q[k] = NORM_ONE;
         if (sd.sn[k]) q[k] = 16'(-q[k]);
      end
      if (sd.zero) begin
         norm_x = '0; norm_y = '0; norm_z = $signed(NORM_ONE);
      end else begin
         norm_x = $signed(q[0]); norm_y = $signed(q[1]); norm_z = $signed(q[2]);
      end
   end

   logic unused_reset;
   assign unused_reset = reset;

endmodule

FILE: rtl/biquadratic_patch_evaluator_unit.sv
// top level: control point store, blending pipeline and output register
//
//  channel | group   | tdata                                  | tuser
//  input   | req_    | x,y,z,u,v,s,t (176 bits)               | func, point_index
//  result  | rsp_    | pos x,y,z, tex u,v, norm x,y,z (184)   | -
//
// one evaluate transaction per cycle while the response side does not stall; the pipe is
// 60 register stages deep, set by the bit-per-stage square root and divide of the normal.
// loads take effect the cycle after acceptance and give no result.
// reset is synchronous and clears valid bits only; control points are unset.
// a stall freezes the whole pipe; req_tready is high when rsp_tready is or the output stage is empty.
`timescale 1ns / 1ps
module biquadratic_patch_evaluator_unit
   import bqpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [175:0] req_tdata,   // point_x, point_y, point_z, point_u, point_v, s, t
   input  logic [7:0]   req_tuser,   // func, point_index
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata    // pos_x,y,z, tex_u,v, norm_x,y,z
);

   localparam int DEPTH = 60;
   localparam int NDEPTH = 54;

   logic advance;
   logic vld_ff [DEPTH];
   assign advance = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   logic accept;
   logic func;
   logic [3:0] idx;
   assign accept = req_tvalid && req_tready;
   assign func = req_tuser[0];
   assign idx = req_tuser[4:1];

   // control point store
   logic [31:0] pt_ff [5][9];
   always_ff @(posedge clock) begin
      if (accept && func == FUNC_LOAD && idx <= LAST_SLOT) begin
         pt_ff[0][idx] <= {8'd0, req_tdata[23:0]};
         pt_ff[1][idx] <= {8'd0, req_tdata[47:24]};
         pt_ff[2][idx] <= {8'd0, req_tdata[71:48]};
         pt_ff[3][idx] <= req_tdata[103:72];
         pt_ff[4][idx] <= req_tdata[135:104];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= accept && func == FUNC_EVAL;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: clamp parameters, offset-binary control points
   logic [16:0] s1_ff, t1_ff;
   logic [32:0] c1_ff [5][9];
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= (req_tdata[152:136] > FRAC_ONE) ? FRAC_ONE : req_tdata[152:136];
         t1_ff <= (req_tdata[169:153] > FRAC_ONE) ? FRAC_ONE : req_tdata[169:153];
         for (int f = 0; f < 5; f++)
            for (int j = 0; j < 9; j++)
               c1_ff[f][j] <= (f < 3) ? {9'd0, pt_ff[f][j][23:0] ^ 24'h800000}
                                      : {1'b0, pt_ff[f][j] ^ 32'h80000000};
      end
   end

   // stage 2: weights
   logic [16:0] s2_ff, t2_ff;
   logic [32:0] c2_ff [5][9];
   weight_type ws2_ff, wt2_ff;
   function automatic weight_type mk_w(input logic [16:0] p);
      weight_type w;
      logic [16:0] q;
      q = FRAC_ONE - p;
      w.w0 = 34'(q) * 34'(q);
      w.w1 = (34'(q) * 34'(p)) << 1;
      w.w2 = 34'(p) * 34'(p);
      return w;
   endfunction
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s1_ff; t2_ff <= t1_ff; c2_ff <= c1_ff;
         ws2_ff <= mk_w(s1_ff);
         wt2_ff <= mk_w(t1_ff);
      end
   end

   // stage 3: first blend products (three per column/row)
   logic [16:0] s3_ff, t3_ff;
   weight_type ws3_ff;
   logic [66:0] pr3_ff [5][3][3], pc3_ff [5][3][3];
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff <= s2_ff; t3_ff <= t2_ff; ws3_ff <= ws2_ff;
         for (int f = 0; f < 5; f++)
            for (int k = 0; k < 3; k++) begin
               pr3_ff[f][k][0] <= 67'(wt2_ff.w0) * 67'(c2_ff[f][k]);
               pr3_ff[f][k][1] <= 67'(wt2_ff.w1) * 67'(c2_ff[f][3+k]);
               pr3_ff[f][k][2] <= 67'(wt2_ff.w2) * 67'(c2_ff[f][6+k]);
               pc3_ff[f][k][0] <= 67'(ws2_ff.w0) * 67'(c2_ff[f][3*k]);
               pc3_ff[f][k][1] <= 67'(ws2_ff.w1) * 67'(c2_ff[f][3*k+1]);
               pc3_ff[f][k][2] <= 67'(ws2_ff.w2) * 67'(c2_ff[f][3*k+2]);
            end
      end
   end

   // stage 4: sum and round intermediates
   logic [16:0] s4_ff, t4_ff;
   weight_type ws4_ff;
   logic [32:0] r4_ff [5][3], c4_ff [3][3];
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff <= s3_ff; t4_ff <= t3_ff; ws4_ff <= ws3_ff;
         for (int f = 0; f < 5; f++)
            for (int k = 0; k < 3; k++) begin
               r4_ff[f][k] <= 33'((pr3_ff[f][k][0] + pr3_ff[f][k][1] + pr3_ff[f][k][2]
                                   + 67'h80000000) >> 32);
               if (f < 3)
                  c4_ff[f][k] <= 33'((pc3_ff[f][k][0] + pc3_ff[f][k][1] + pc3_ff[f][k][2]
                                      + 67'h80000000) >> 32);
            end
      end
   end

   // stage 5: second blend products and derivative products
   logic [66:0] pf5_ff [5][3];
   logic signed [63:0] ds5_ff [3][2], dt5_ff [3][2];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int f = 0; f < 5; f++) begin
            pf5_ff[f][0] <= 67'(ws4_ff.w0) * 67'(r4_ff[f][0]);
            pf5_ff[f][1] <= 67'(ws4_ff.w1) * 67'(r4_ff[f][1]);
            pf5_ff[f][2] <= 67'(ws4_ff.w2) * 67'(r4_ff[f][2]);
         end
         for (int k = 0; k < 3; k++) begin
            ds5_ff[k][0] <= 64'($signed({1'b0, FRAC_ONE - s4_ff}))
                            * (64'($signed({1'b0, r4_ff[k][1]})) - 64'($signed({1'b0, r4_ff[k][0]})));
            ds5_ff[k][1] <= 64'($signed({1'b0, s4_ff}))
                            * (64'($signed({1'b0, r4_ff[k][2]})) - 64'($signed({1'b0, r4_ff[k][1]})));
            dt5_ff[k][0] <= 64'($signed({1'b0, FRAC_ONE - t4_ff}))
                            * (64'($signed({1'b0, c4_ff[k][1]})) - 64'($signed({1'b0, c4_ff[k][0]})));
            dt5_ff[k][1] <= 64'($signed({1'b0, t4_ff}))
                            * (64'($signed({1'b0, c4_ff[k][2]})) - 64'($signed({1'b0, c4_ff[k][1]})));
         end
      end
   end

   // stage 6: final position/texture and derivatives
   logic [31:0] pos6_ff [5];
   logic signed [63:0] ds6_ff [3], dt6_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int f = 0; f < 5; f++)
            pos6_ff[f] <= 32'((pf5_ff[f][0] + pf5_ff[f][1] + pf5_ff[f][2]
                               + 67'h80000000) >> 32)
                          ^ ((f < 3) ? 32'h00800000 : 32'h80000000);
         for (int k = 0; k < 3; k++) begin
            ds6_ff[k] <= ds5_ff[k][0] + ds5_ff[k][1];
            dt6_ff[k] <= dt5_ff[k][0] + dt5_ff[k][1];
         end
      end
   end

   // normal pipeline
   logic signed [15:0] nx, ny, nz;
   bqpe_normal_unit u_norm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .dt_x    (dt6_ff[0]),
      .dt_y    (dt6_ff[1]),
      .dt_z    (dt6_ff[2]),
      .ds_x    (ds6_ff[0]),
      .ds_y    (ds6_ff[1]),
      .ds_z    (ds6_ff[2]),
      .norm_x  (nx),
      .norm_y  (ny),
      .norm_z  (nz)
   );

   // delay line for position/texture to match normal latency
   logic [31:0] pd_ff [NDEPTH][5];
   always_ff @(posedge clock) begin
      if (advance) begin
         pd_ff[0] <= pos6_ff;
         for (int i = 1; i < NDEPTH; i++) pd_ff[i] <= pd_ff[i-1];
      end
   end

   assign rsp_tdata = {nz, ny, nx,
                       pd_ff[NDEPTH-1][4], pd_ff[NDEPTH-1][3],
                       pd_ff[NDEPTH-1][2][23:0], pd_ff[NDEPTH-1][1][23:0],
                       pd_ff[NDEPTH-1][0][23:0]};

   logic [8:0] unused_bits;
   assign unused_bits = {req_tdata[175:170], req_tuser[7:5]};

endmodule

FILE: test/tb_top.sv
// testbench: patch evaluator checked against an in-bench fixed-point predictor
`timescale 1ns / 1ps
module tb_top
   import bqpe_pkg::*;
();

   // one input transaction as the sender sees it
   typedef struct {
      logic        func;
      logic [3:0]  slot;
      logic [23:0] x, y, z;
      logic [31:0] u, v;
      logic [16:0] s, t;
   } patch_req_type;

   typedef longint vec3_type [3];
   typedef longint unsigned uvec3_type [3];

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;   // point_x, point_y, point_z, point_u, point_v, s, t
   logic [7:0]   req_tuser = '0;   // func, point_index
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;        // pos_x,y,z, tex_u,v, norm_x,y,z

   patch_req_type pending_reqs[$];
   result_type expected_surf[$];
   patch_req_type cur_req;

   // control point copy, offset binary (sign bit flipped)
   longint unsigned pos_pts [3][9];
   longint unsigned tex_pts [2][9];

   int errors = 0;
   int n_loads = 0;
   int n_evals = 0;
   int n_checked = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit calm;

   biquadratic_patch_evaluator_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // bernstein weights in q.32
   function automatic uvec3_type bern_weights(input longint unsigned p);
      uvec3_type w;
      longint unsigned q;
      q = 64'd65536 - p;
      w[0] = q * q;
      w[1] = 64'd2 * q * p;
      w[2] = p * p;
      return w;
   endfunction

   // weighted sum of three offset-binary values, rounded half up
   function automatic longint unsigned mix3(input longint unsigned a, b, c,
                                            input uvec3_type w);
      longint unsigned acc;
      acc = w[0] * a + w[1] * b + w[2] * c;
      return (acc + 64'h8000_0000) >> 32;
   endfunction

   function automatic longint slope(input uvec3_type v, input longint unsigned p);
      longint d1, d2;
      d1 = longint'(v[1]) - longint'(v[0]);
      d2 = longint'(v[2]) - longint'(v[1]);
      return longint'(64'd65536 - p) * d1 + longint'(p) * d2;
   endfunction

   // power-of-two scaling so the largest magnitude lands in [2^29, 2^30)
   function automatic bit scale3(input vec3_type v, output vec3_type o);
      longint unsigned m[3];
      longint unsigned top;
      top = 0;
      for (int k = 0; k < 3; k++) begin
         m[k] = (v[k] < 0) ? longint'(-v[k]) : v[k];
         if (m[k] > top) top = m[k];
      end
      for (int k = 0; k < 3; k++) o[k] = 0;
      if (top == 0) return 1'b0;
      while (top >= 64'd1 << 30) begin
         for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
         top = top >> 1;
      end
      while (top < 64'd1 << 29) begin
         for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
         top = top << 1;
      end
      for (int k = 0; k < 3; k++) o[k] = (v[k] < 0) ? -longint'(m[k]) : longint'(m[k]);
      return 1'b1;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // surface point, texture and normal at (s,t) from the current control points
   function automatic result_type eval_surface(input logic [16:0] s_in, t_in);
      result_type res;
      longint unsigned s, t, len2, len, m, q;
      uvec3_type ws, wt, r, c;
      vec3_type ds, dt, a, b, n, sn;
      logic [15:0] nc[3];
      s = (s_in > FRAC_ONE) ? 64'd65536 : 64'(s_in);
      t = (t_in > FRAC_ONE) ? 64'd65536 : 64'(t_in);
      ws = bern_weights(s);
      wt = bern_weights(t);
      for (int f = 0; f < 5; f++) begin
         longint unsigned pts[9];
         longint unsigned outv;
         for (int i = 0; i < 9; i++) pts[i] = (f < 3) ? pos_pts[f][i] : tex_pts[f-3][i];
         for (int j = 0; j < 3; j++) begin
            r[j] = mix3(pts[j], pts[3+j], pts[6+j], wt);
            c[j] = mix3(pts[3*j], pts[3*j+1], pts[3*j+2], ws);
         end
         outv = mix3(r[0], r[1], r[2], ws);
         case (f)
            0: res.pos_x = outv[23:0] ^ 24'h800000;
            1: res.pos_y = outv[23:0] ^ 24'h800000;
            2: res.pos_z = outv[23:0] ^ 24'h800000;
            3: res.tex_u = outv[31:0] ^ 32'h80000000;
            default: res.tex_v = outv[31:0] ^ 32'h80000000;
         endcase
         if (f < 3) begin
            ds[f] = slope(r, s);
            dt[f] = slope(c, t);
         end
      end
      void'(scale3(dt, a));
      void'(scale3(ds, b));
      n[0] = a[1] * b[2] - a[2] * b[1];
      n[1] = a[2] * b[0] - a[0] * b[2];
      n[2] = a[0] * b[1] - a[1] * b[0];
      if (!scale3(n, sn)) begin
         nc[0] = '0;
         nc[1] = '0;
         nc[2] = NORM_ONE;
      end else begin
         len2 = 0;
         for (int k = 0; k < 3; k++) begin
            m = (sn[k] < 0) ? longint'(-sn[k]) : sn[k];
            len2 += m * m;
         end
         len = int_sqrt(len2);
         for (int k = 0; k < 3; k++) begin
            m = (sn[k] < 0) ? longint'(-sn[k]) : sn[k];
            q = (m * 64'd16384 + len / 2) / len;
            if (q > 64'd16384) q = 64'd16384;
            nc[k] = (sn[k] < 0) ? -q[15:0] : q[15:0];
         end
      end
      res.norm_x = nc[0];
      res.norm_y = nc[1];
      res.norm_z = nc[2];
      return res;
   endfunction

   // update the point store or queue the expected surface result
   task automatic apply_req(input patch_req_type rq);
      if (rq.func == FUNC_LOAD) begin
         n_loads++;
         if (rq.slot <= LAST_SLOT) begin
            pos_pts[0][rq.slot] = {40'd0, rq.x ^ 24'h800000};
            pos_pts[1][rq.slot] = {40'd0, rq.y ^ 24'h800000};
            pos_pts[2][rq.slot] = {40'd0, rq.z ^ 24'h800000};
            tex_pts[0][rq.slot] = {32'd0, rq.u ^ 32'h80000000};
            tex_pts[1][rq.slot] = {32'd0, rq.v ^ 32'h80000000};
         end
      end else begin
         n_evals++;
         expected_surf.push_back(eval_surface(rq.s, rq.t));
      end
   endtask

   function automatic logic [23:0] rand_pos(input int mode);
      case (mode)
         0: return 24'($urandom());
         1: return 24'($urandom_range(0, 8000) - 4000);
         default: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
      endcase
   endfunction

   function automatic logic [16:0] rand_param();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return FRAC_ONE;
         2: return 17'($urandom());
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic patch_req_type make_req(input logic func, input logic [3:0] slot,
                                              input int mode);
      patch_req_type rq;
      rq.func = func;
      rq.slot = slot;
      rq.x = rand_pos(mode);
      rq.y = rand_pos(mode);
      rq.z = rand_pos(mode);
      rq.u = (mode == 1) ? $urandom_range(0, 200000) - 100000 : $urandom();
      rq.v = (mode == 1) ? $urandom_range(0, 200000) - 100000 : $urandom();
      rq.s = rand_param();
      rq.t = rand_param();
      return rq;
   endfunction

   // sender: presents queued transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) apply_req(cur_req);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 12);
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {6'd0, cur_req.t, cur_req.s, cur_req.v, cur_req.u,
                             cur_req.z, cur_req.y, cur_req.x};
               req_tuser <= {3'd0, cur_req.slot, cur_req.func};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls and field-by-field compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_surf.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, rsp_tdata);
               errors++;
            end else begin
               result_type e;
               result_type got;
               e = expected_surf.pop_front();
               got.pos_x = rsp_tdata[23:0];
               got.pos_y = rsp_tdata[47:24];
               got.pos_z = rsp_tdata[71:48];
               got.tex_u = rsp_tdata[103:72];
               got.tex_v = rsp_tdata[135:104];
               got.norm_x = rsp_tdata[151:136];
               got.norm_y = rsp_tdata[167:152];
               got.norm_z = rsp_tdata[183:168];
               n_checked++;
               if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y || got.pos_z !== e.pos_z) begin
                  $display("%0t: position mismatch expected %0d %0d %0d actual %0d %0d %0d",
                           $time, e.pos_x, e.pos_y, e.pos_z, got.pos_x, got.pos_y, got.pos_z);
                  errors++;
               end
               if (got.tex_u !== e.tex_u || got.tex_v !== e.tex_v) begin
                  $display("%0t: texture mismatch expected %0d %0d actual %0d %0d",
                           $time, e.tex_u, e.tex_v, got.tex_u, got.tex_v);
                  errors++;
               end
               if (got.norm_x !== e.norm_x || got.norm_y !== e.norm_y ||
                   got.norm_z !== e.norm_z) begin
                  $display("%0t: normal mismatch expected %0d %0d %0d actual %0d %0d %0d",
                           $time, e.norm_x, e.norm_y, e.norm_z,
                           got.norm_x, got.norm_y, got.norm_z);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_stall = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always_comb calm = pending_reqs.size() < 150;

   // stimulus and end of run
   initial begin
      patch_req_type rq;
      int mode;
      // directed: a curved patch with extreme corners
      for (int i = 0; i < 9; i++) begin
         rq = make_req(FUNC_LOAD, i[3:0], 1);
         rq.x = 24'((i % 3) * 2560);
         rq.y = 24'((i / 3) * 2560);
         rq.z = (i == 4) ? 24'd5000 : 24'(-300 * i);
         if (i == 0) begin
            rq.x = 24'h7FFFFF; rq.u = 32'h7FFFFFFF; rq.v = 32'h80000000;
         end
         if (i == 8) begin
            rq.x = 24'h800000; rq.y = 24'h7FFFFF; rq.u = 32'h80000000; rq.v = 32'h7FFFFFFF;
         end
         pending_reqs.push_back(rq);
      end
      // load to a slot past the last one is dropped
      rq = make_req(FUNC_LOAD, 4'd15, 0);
      pending_reqs.push_back(rq);
      for (int i = 0; i < 7; i++) begin
         rq = make_req(FUNC_EVAL, 4'($urandom()), 0);
         rq.s = (i == 1 || i == 3) ? FRAC_ONE : (i == 4) ? 17'd32768 :
                (i == 5) ? 17'h1FFFF : (i == 6) ? 17'd70000 : 17'd0;
         rq.t = (i == 1 || i == 2) ? FRAC_ONE : (i == 4) ? 17'd32768 :
                (i == 5) ? 17'h1FFFF : (i == 6) ? 17'd5 : 17'd0;
         pending_reqs.push_back(rq);
      end
      // flat degenerate patch: every point at the same position
      for (int i = 0; i < 9; i++) begin
         rq = make_req(FUNC_LOAD, i[3:0], 0);
         rq.x = 24'd100; rq.y = 24'd200; rq.z = 24'd300;
         pending_reqs.push_back(rq);
      end
      rq = make_req(FUNC_EVAL, 4'd0, 0);
      rq.s = 17'd12345;
      rq.t = 17'd54321;
      pending_reqs.push_back(rq);

      // random: reload bursts with evaluate runs in between
      for (int i = 0; i < 1850; ) begin
         if ($urandom_range(0, 9) == 0) begin
            mode = $urandom_range(0, 3);
            for (int j = $urandom_range(1, 9); j > 0; j--) begin
               rq = make_req(FUNC_LOAD, 4'(($urandom_range(0, 9) == 0) ? $urandom() :
                             $urandom_range(0, 8)), (mode == 3) ? 1 : mode);
               pending_reqs.push_back(rq);
               i++;
            end
         end else begin
            for (int j = $urandom_range(1, 30); j > 0; j--) begin
               rq = make_req(FUNC_EVAL, 4'($urandom()), 0);
               pending_reqs.push_back(rq);
               i++;
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_tvalid);
      @(posedge clock);
      while (expected_surf.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d load and %0d evaluate transactions, %0d results checked",
               n_loads, n_evals, n_checked);
      $display("extreme points and params, dropped slot loads, flat patch normal included");
      if (errors == 0 && expected_surf.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: biquadratic_patch_evaluator_unit.f
rtl/bqpe_pkg.sv
rtl/bqpe_normal_unit.sv
rtl/biquadratic_patch_evaluator_unit.sv
test/tb_top.sv
